>>> sv/sed_pkg.sv
`timescale 1ns / 1ps
// Package for the sparse Euclidean distance unit: sizes, command codes,
// controller states and the command and status bundles.
// Depends on nothing; every other file uses it.
package sed_pkg;

  localparam int MAX_NONZEROS = 64;
  localparam int COLUMN_BITS  = 16;

  localparam int COL_IN_W  = 16;
  localparam int VAL_W     = 16;
  localparam int DIST_W    = 24;
  localparam int SUM_W     = 48;
  localparam int SQ_W      = 32;
  localparam int COL_W     = (COLUMN_BITS < COL_IN_W) ? COLUMN_BITS : COL_IN_W;
  localparam int IDX_W     = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int CNT_W     = $clog2(MAX_NONZEROS + 1);

  typedef logic [1:0] command_t;
  localparam command_t CMD_ADD_A  = 2'd0;
  localparam command_t CMD_ADD_B  = 2'd1;
  localparam command_t CMD_FINISH = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_A,
    S_LOAD_B,
    S_CMP,
    S_ACC_PAIR,
    S_MISS_A,
    S_ACC_A,
    S_B_RD,
    S_B_SQ,
    S_ACC_B,
    S_SQ_INIT,
    S_SQRT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic clr_j;
    logic clr_hit;
    logic cmp;
    logic miss_a;
    logic sq_b;
    logic acc;
    logic inc_i;
    logic inc_j;
    logic sq_init;
    logic sq_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic na_zero;
    logic nb_zero;
    logic i_last;
    logic j_last;
    logic sqrt_last;
    logic out_busy;
  } ctrl_sts_t;

endpackage

>>> sv/sed_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the sparse Euclidean distance unit.
// Depends on sed_pkg for field widths.
interface sed_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     command;
  logic [sed_pkg::COL_IN_W-1:0]   column;
  logic signed [sed_pkg::VAL_W-1:0] value;
  modport source (output valid, command, column, value, input ready);
  modport sink   (input valid, command, column, value, output ready);
endinterface

interface sed_out_if;
  logic                         valid;
  logic                         ready;
  logic [sed_pkg::DIST_W-1:0]   distance;
  logic                         overflow;
  modport source (output valid, distance, overflow, input ready);
  modport sink   (input valid, distance, overflow, output ready);
endinterface

>>> sv/sed_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences loading, the pairwise walk, the
// square root and the result transfer. Depends on sed_pkg.
module sed_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_command,
  output logic               in_ready,
  input  sed_pkg::ctrl_sts_t sts,
  output sed_pkg::ctrl_cmd_t cmd
);
  import sed_pkg::*;

  state_t state;
  state_t state_next;
  logic   take;

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take && in_command == CMD_FINISH) begin
          if (!sts.na_zero) state_next = S_LOAD_A;
          else if (!sts.nb_zero) state_next = S_B_RD;
          else state_next = S_SQ_INIT;
        end
      end
      S_LOAD_A:   state_next = sts.nb_zero ? S_MISS_A : S_LOAD_B;
      S_LOAD_B:   state_next = S_CMP;
      S_CMP:      state_next = S_ACC_PAIR;
      S_ACC_PAIR: state_next = sts.j_last ? S_MISS_A : S_LOAD_B;
      S_MISS_A:   state_next = S_ACC_A;
      S_ACC_A: begin
        if (!sts.i_last) state_next = S_LOAD_A;
        else if (!sts.nb_zero) state_next = S_B_RD;
        else state_next = S_SQ_INIT;
      end
      S_B_RD:     state_next = S_B_SQ;
      S_B_SQ:     state_next = S_ACC_B;
      S_ACC_B:    state_next = sts.j_last ? S_SQ_INIT : S_B_RD;
      S_SQ_INIT:  state_next = S_SQRT;
      S_SQRT:     state_next = sts.sqrt_last ? S_DONE : S_SQRT;
      S_DONE:     state_next = sts.out_busy ? S_DONE : S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load_a = take && in_command == CMD_ADD_A;
        cmd.load_b = take && in_command == CMD_ADD_B;
        cmd.start  = take && in_command == CMD_FINISH;
      end
      S_LOAD_A: begin
        cmd.clr_j   = 1'b1;
        cmd.clr_hit = 1'b1;
      end
      S_CMP:      cmd.cmp = 1'b1;
      S_ACC_PAIR: begin
        cmd.acc   = 1'b1;
        cmd.inc_j = 1'b1;
      end
      S_MISS_A:   cmd.miss_a = 1'b1;
      S_ACC_A: begin
        cmd.acc   = 1'b1;
        cmd.inc_i = 1'b1;
        cmd.clr_j = 1'b1;
      end
      S_B_SQ:     cmd.sq_b = 1'b1;
      S_ACC_B: begin
        cmd.acc   = 1'b1;
        cmd.inc_j = 1'b1;
      end
      S_SQ_INIT:  cmd.sq_init = 1'b1;
      S_SQRT:     cmd.sq_step = 1'b1;
      S_DONE:     cmd.emit = !sts.out_busy;
      default:    cmd = '0;
    endcase
  end

endmodule

>>> sv/sed_dp.sv
`timescale 1ns / 1ps
// Datapath: row stores, walk counters, squarer, saturating accumulator,
// bit-pair square root and the result register. Depends on sed_pkg.
module sed_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  sed_pkg::ctrl_cmd_t          cmd,
  output sed_pkg::ctrl_sts_t          sts,
  input  logic [sed_pkg::COL_IN_W-1:0] in_column,
  input  logic [sed_pkg::VAL_W-1:0]   in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sed_pkg::DIST_W-1:0]  out_distance,
  output logic                        out_overflow
);
  import sed_pkg::*;

  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [SUM_W-1:0] BIT_FIRST = {2'b01, {(SUM_W-2){1'b0}}};

  // Row stores.
  logic [COL_W-1:0] a_col_mem [MAX_NONZEROS];
  logic [VAL_W-1:0] a_val_mem [MAX_NONZEROS];
  logic [COL_W-1:0] b_col_mem [MAX_NONZEROS];
  logic [VAL_W-1:0] b_val_mem [MAX_NONZEROS];
  logic [COL_W-1:0] a_col_q, b_col_q;
  logic [VAL_W-1:0] a_val_q, b_val_q;

  logic [CNT_W-1:0] na, nb;
  logic             dropped;
  logic [IDX_W-1:0] i, j;
  logic             hit;
  logic [MAX_NONZEROS-1:0] b_hit;
  logic [SQ_W-1:0]  sq;
  logic [SUM_W-1:0] sum;
  logic             sat;
  logic [SUM_W-1:0] rem, res, bitv;

  logic signed [VAL_W:0]     diff;
  logic signed [2*VAL_W+1:0] diff_sq;
  logic signed [2*VAL_W+1:0] a_sq, b_sq;
  logic [SUM_W:0]            sum_ext;
  logic [SUM_W-1:0]          trial;
  logic                      a_full, b_full;

  assign a_full = (na == CNT_W'(MAX_NONZEROS));
  assign b_full = (nb == CNT_W'(MAX_NONZEROS));

  // Counts and drop flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      na      <= '0;
      nb      <= '0;
      dropped <= 1'b0;
    end else if (cmd.emit) begin
      na      <= '0;
      nb      <= '0;
      dropped <= 1'b0;
    end else begin
      if (cmd.load_a) begin
        if (a_full) dropped <= 1'b1;
        else na <= na + 1'b1;
      end
      if (cmd.load_b) begin
        if (b_full) dropped <= 1'b1;
        else nb <= nb + 1'b1;
      end
    end
  end

  // Store writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.load_a && !a_full) begin
      a_col_mem[na[IDX_W-1:0]] <= in_column[COL_W-1:0];
      a_val_mem[na[IDX_W-1:0]] <= in_value;
    end
    if (cmd.load_b && !b_full) begin
      b_col_mem[nb[IDX_W-1:0]] <= in_column[COL_W-1:0];
      b_val_mem[nb[IDX_W-1:0]] <= in_value;
    end
    a_col_q <= a_col_mem[i];
    a_val_q <= a_val_mem[i];
    b_col_q <= b_col_mem[j];
    b_val_q <= b_val_mem[j];
  end

  // Walk counters and match flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      i     <= '0;
      j     <= '0;
      hit   <= 1'b0;
      b_hit <= '0;
    end else begin
      if (cmd.start) begin
        i     <= '0;
        j     <= '0;
        b_hit <= '0;
      end
      if (cmd.inc_i) i <= i + 1'b1;
      if (cmd.clr_j) j <= '0;
      else if (cmd.inc_j) j <= j + 1'b1;
      if (cmd.clr_hit) hit <= 1'b0;
      if (cmd.cmp && a_col_q == b_col_q) begin
        hit      <= 1'b1;
        b_hit[j] <= 1'b1;
      end
    end
  end

  // Squarer: one product a cycle into a register, on cmp, miss_a or sq_b.
  assign diff    = $signed({a_val_q[VAL_W-1], a_val_q}) - $signed({b_val_q[VAL_W-1], b_val_q});
  assign diff_sq = diff * diff;
  assign a_sq    = $signed({a_val_q[VAL_W-1], a_val_q}) * $signed({a_val_q[VAL_W-1], a_val_q});
  assign b_sq    = $signed({b_val_q[VAL_W-1], b_val_q}) * $signed({b_val_q[VAL_W-1], b_val_q});

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      sq <= (a_col_q == b_col_q) ? diff_sq[SQ_W-1:0] : '0;
    end else if (cmd.miss_a) begin
      sq <= hit ? '0 : a_sq[SQ_W-1:0];
    end else if (cmd.sq_b) begin
      sq <= b_hit[j] ? '0 : b_sq[SQ_W-1:0];
    end
  end

  // Saturating accumulator.
  assign sum_ext = {1'b0, sum} + {{(SUM_W+1-SQ_W){1'b0}}, sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      sat <= 1'b0;
    end else if (cmd.start) begin
      sum <= '0;
      sat <= 1'b0;
    end else if (cmd.acc) begin
      if (sum_ext[SUM_W]) begin
        sum <= SUM_MAX;
        sat <= 1'b1;
      end else begin
        sum <= sum_ext[SUM_W-1:0];
      end
    end
  end

  // Square root, one result bit a cycle while sq_step is set.
  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      rem  <= sum;
      res  <= '0;
      bitv <= BIT_FIRST;
    end else if (cmd.sq_step) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_distance <= res[DIST_W-1:0];
      out_overflow <= dropped || sat;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.na_zero   = (na == '0);
    sts.nb_zero   = (nb == '0);
    sts.i_last    = ((CNT_W'(i) + 1'b1) == na);
    sts.j_last    = ((CNT_W'(j) + 1'b1) == nb);
    sts.sqrt_last = bitv[0];
    sts.out_busy  = out_valid;
  end

endmodule

>>> sv/sparse_euclidean_distance_unit.sv
`timescale 1ns / 1ps
// Top level of the sparse Euclidean distance unit: controller and datapath.
// Depends on sed_pkg, sed_if.sv, sed_ctrl and sed_dp.
//
//   Channel  Dir  Payload                    Notes
//   in_ch    in   command, column, value     add to row A, add to row B, finish
//   out_ch   out  distance, overflow         one transfer per finish
//
// Adds are taken back to back while idle. A finish is paced by the pairwise
// walk through the row stores and the 24-step square root.
// Reset clears the counts, the drop flag and the result valid flag.
// Input is taken only while idle; a waiting result stalls only the next finish.
module sparse_euclidean_distance_unit (
  input logic       clk,
  input logic       rst,
  sed_in_if.sink    in_ch,
  sed_out_if.source out_ch
);
  import sed_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencing.
  sed_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Arithmetic and storage.
  sed_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_column    (in_ch.column),
    .in_value     (in_ch.value),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_distance (out_ch.distance),
    .out_overflow (out_ch.overflow)
  );

endmodule
